// ----- design/affra_pkg.sv -----
// Package for the layered atlas first-fit rectangle allocator.
// Holds field widths, codes, payload structs and controller/datapath link types.
// Used by affra_ctrl, affra_dp, atlas_first_fit_rect_allocator_top and the bench; depends on nothing.
package affra_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_W     = 4;
    localparam int SCAN_W     = 5;   // candidate index 0..NUM_SLOTS
    localparam int COORD_W    = 12;
    localparam int SIZE_W     = 13;
    localparam int EXT_W      = 14;  // candidate edges and edge sums
    localparam int LAYER_W    = 8;
    localparam int LCNT_W     = 9;
    localparam int CHAN_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [SIZE_W-1:0] MAX_DIM           = 13'd4096;
    localparam logic [LCNT_W-1:0] MAX_LAYERS        = 9'd256;
    localparam logic [CHAN_W-1:0] REQUIRED_CHANNELS = 4'd4;

    localparam logic [SIZE_W-1:0] ATLAS_WIDTH_RESET  = 13'd2048;
    localparam logic [SIZE_W-1:0] ATLAS_HEIGHT_RESET = 13'd2048;
    localparam logic [LCNT_W-1:0] ATLAS_LAYERS_RESET = 9'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_LAYERS = 2'd2;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_LOOKUP  = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_FORMAT = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_EMPTY_SLOT = 3'd4
    } status_t;

    // Which fields a response carries besides its status.
    typedef enum logic [1:0] {
        RESP_STATUS = 2'd0,
        RESP_ECHO   = 2'd1,
        RESP_LOOKUP = 2'd2,
        RESP_ALLOC  = 2'd3
    } resp_kind_t;

    typedef struct packed {
        action_t             action;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   rect_width;
        logic [SIZE_W-1:0]   rect_height;
        logic [CHAN_W-1:0]   channel_count;
    } request_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot_out;
        logic [COORD_W-1:0]  origin_x;
        logic [COORD_W-1:0]  origin_y;
        logic [LAYER_W-1:0]  origin_layer;
        logic [SIZE_W-1:0]   size_x;
        logic [SIZE_W-1:0]   size_y;
    } result_t;

    typedef struct packed {
        logic       latch_req;
        logic       layer_clear;
        logic       layer_inc;
        logic       scan_init;
        logic       cand_load;
        logic       cand_check;
        logic       commit;
        logic       release_slot;
        logic       resp_load;
        resp_kind_t resp_kind;
        status_t    resp_status;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    fmt_ok;
        logic    table_full;
        logic    slot_hit;
        logic    no_layers;
        logic    layer_last;
        logic    scan_last;
        logic    found;
    } dp_status_t;

endpackage

// ----- design/affra_dp.sv -----
// Datapath of the atlas allocator: configuration, rectangle table, candidate
// scan registers, fit check and response register. Driven by affra_ctrl.
// Depends on affra_pkg.
module affra_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [affra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [affra_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  affra_pkg::request_t                  request,
    input  affra_pkg::ctrl_cmd_t                 cmd,
    output affra_pkg::dp_status_t                st,
    output affra_pkg::result_t                   result
);

    localparam int N = affra_pkg::NUM_SLOTS;

    logic [affra_pkg::SIZE_W-1:0]   aw_cfg_reg;
    logic [affra_pkg::SIZE_W-1:0]   ah_cfg_reg;
    logic [affra_pkg::LCNT_W-1:0]   layers_cfg_reg;

    affra_pkg::request_t            req_reg;
    logic [affra_pkg::EXT_W-1:0]    w1_reg;
    logic [affra_pkg::EXT_W-1:0]    h1_reg;

    logic [N-1:0]                   entry_valid_reg;
    logic [affra_pkg::COORD_W-1:0]  entry_x_reg      [N];
    logic [affra_pkg::COORD_W-1:0]  entry_y_reg      [N];
    logic [affra_pkg::LAYER_W-1:0]  entry_layer_reg  [N];
    logic [affra_pkg::SIZE_W-1:0]   entry_w_reg      [N];
    logic [affra_pkg::SIZE_W-1:0]   entry_h_reg      [N];
    logic [affra_pkg::SIZE_W-1:0]   entry_far_x_reg  [N];
    logic [affra_pkg::SIZE_W-1:0]   entry_far_y_reg  [N];

    logic [affra_pkg::LCNT_W-1:0]   layer_reg;
    logic [affra_pkg::SCAN_W-1:0]   scan_i_reg;
    logic [affra_pkg::SCAN_W-1:0]   scan_j_reg;
    logic                           found_reg;
    logic [affra_pkg::COORD_W-1:0]  best_x_reg;
    logic [affra_pkg::COORD_W-1:0]  best_y_reg;
    logic [affra_pkg::EXT_W-1:0]    cand_x_reg;
    logic [affra_pkg::EXT_W-1:0]    cand_xe_reg;
    logic [affra_pkg::EXT_W-1:0]    cand_y_reg;
    logic [affra_pkg::EXT_W-1:0]    cand_ye_reg;
    affra_pkg::result_t             result_reg;

    logic [affra_pkg::SIZE_W-1:0]   aw;
    logic [affra_pkg::SIZE_W-1:0]   ah;
    logic [affra_pkg::LCNT_W-1:0]   nl;
    logic [affra_pkg::EXT_W-1:0]    aw_ext;
    logic [affra_pkg::EXT_W-1:0]    ah_ext;
    logic [N:0]                     cmask;
    logic                           next_i_ok;
    logic                           next_j_ok;
    logic [affra_pkg::SCAN_W-1:0]   next_i;
    logic [affra_pkg::SCAN_W-1:0]   next_j;
    logic [affra_pkg::SLOT_W-1:0]   free_idx;
    logic                           table_full;
    logic [affra_pkg::SCAN_W-1:0]   im1;
    logic [affra_pkg::SCAN_W-1:0]   jm1;
    logic [affra_pkg::EXT_W-1:0]    load_x;
    logic [affra_pkg::EXT_W-1:0]    load_xe;
    logic [affra_pkg::EXT_W-1:0]    load_y;
    logic [affra_pkg::EXT_W-1:0]    load_ye;
    logic                           overlap_any;
    logic                           fits;
    logic                           better;
    logic [affra_pkg::SIZE_W-1:0]   commit_far_x;
    logic [affra_pkg::SIZE_W-1:0]   commit_far_y;
    affra_pkg::result_t             result_next;

    // Atlas bounds after clamping.
    always_comb
    begin
        aw = (aw_cfg_reg > affra_pkg::MAX_DIM) ? affra_pkg::MAX_DIM : aw_cfg_reg;
        ah = (ah_cfg_reg > affra_pkg::MAX_DIM) ? affra_pkg::MAX_DIM : ah_cfg_reg;
        nl = (layers_cfg_reg > affra_pkg::MAX_LAYERS) ? affra_pkg::MAX_LAYERS
                                                      : layers_cfg_reg;
        aw_ext = {1'b0, aw};
        ah_ext = {1'b0, ah};
    end

    // Candidate index 0 is the zero edge; index k+1 is the far edge of entry k,
    // present only if that entry sits on the layer being searched.
    always_comb
    begin
        cmask[0] = 1'b1;
        for (int k = 0; k < N; k++)
        begin
            cmask[k+1] = entry_valid_reg[k]
                && (entry_layer_reg[k] == layer_reg[affra_pkg::LAYER_W-1:0]);
        end
    end

    always_comb
    begin
        next_i_ok = 1'b0;
        next_j_ok = 1'b0;
        next_i    = '0;
        next_j    = '0;
        for (int b = N; b >= 0; b--)
        begin
            if (cmask[b] && (affra_pkg::SCAN_W'(b) > scan_i_reg))
            begin
                next_i_ok = 1'b1;
                next_i    = affra_pkg::SCAN_W'(b);
            end
            if (cmask[b] && (affra_pkg::SCAN_W'(b) > scan_j_reg))
            begin
                next_j_ok = 1'b1;
                next_j    = affra_pkg::SCAN_W'(b);
            end
        end
    end

    always_comb
    begin
        free_idx = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (!entry_valid_reg[k])
            begin
                free_idx = affra_pkg::SLOT_W'(k);
            end
        end
        table_full = &entry_valid_reg;
    end

    // Candidate edges: the origin and the origin plus the requested size.
    always_comb
    begin
        im1 = scan_i_reg - affra_pkg::SCAN_W'(1);
        jm1 = scan_j_reg - affra_pkg::SCAN_W'(1);
        if (scan_j_reg == '0)
        begin
            load_x  = '0;
            load_xe = {1'b0, req_reg.rect_width};
        end
        else
        begin
            load_x  = {1'b0, entry_far_x_reg[jm1[affra_pkg::SLOT_W-1:0]]}
                      + affra_pkg::EXT_W'(1);
            load_xe = {1'b0, entry_far_x_reg[jm1[affra_pkg::SLOT_W-1:0]]} + w1_reg;
        end
        if (scan_i_reg == '0)
        begin
            load_y  = '0;
            load_ye = {1'b0, req_reg.rect_height};
        end
        else
        begin
            load_y  = {1'b0, entry_far_y_reg[im1[affra_pkg::SLOT_W-1:0]]}
                      + affra_pkg::EXT_W'(1);
            load_ye = {1'b0, entry_far_y_reg[im1[affra_pkg::SLOT_W-1:0]]} + h1_reg;
        end
    end

    // Touching edges count as overlap.
    always_comb
    begin
        overlap_any = 1'b0;
        for (int k = 0; k < N; k++)
        begin
            if (cmask[k+1]
                && ({2'b0, entry_x_reg[k]} <= cand_xe_reg)
                && ({1'b0, entry_far_x_reg[k]} >= cand_x_reg)
                && ({2'b0, entry_y_reg[k]} <= cand_ye_reg)
                && ({1'b0, entry_far_y_reg[k]} >= cand_y_reg))
            begin
                overlap_any = 1'b1;
            end
        end
        fits = (cand_x_reg < aw_ext) && (cand_y_reg < ah_ext)
            && (cand_xe_reg <= aw_ext) && (cand_ye_reg <= ah_ext) && !overlap_any;
        better = !found_reg
            || (cand_y_reg < {2'b0, best_y_reg})
            || ((cand_y_reg == {2'b0, best_y_reg}) && (cand_x_reg < {2'b0, best_x_reg}));
    end

    assign commit_far_x = {1'b0, best_x_reg} + req_reg.rect_width;
    assign commit_far_y = {1'b0, best_y_reg} + req_reg.rect_height;

    always_comb
    begin
        result_next        = '0;
        result_next.status = cmd.resp_status;
        case (cmd.resp_kind)
            affra_pkg::RESP_STATUS:
            begin
            end
            affra_pkg::RESP_ECHO:
            begin
                result_next.slot_out = req_reg.slot;
            end
            affra_pkg::RESP_LOOKUP:
            begin
                result_next.slot_out     = req_reg.slot;
                result_next.origin_x     = entry_x_reg[req_reg.slot];
                result_next.origin_y     = entry_y_reg[req_reg.slot];
                result_next.origin_layer = entry_layer_reg[req_reg.slot];
                result_next.size_x       = entry_w_reg[req_reg.slot];
                result_next.size_y       = entry_h_reg[req_reg.slot];
            end
            affra_pkg::RESP_ALLOC:
            begin
                result_next.slot_out     = free_idx;
                result_next.origin_x     = best_x_reg;
                result_next.origin_y     = best_y_reg;
                result_next.origin_layer = layer_reg[affra_pkg::LAYER_W-1:0];
                result_next.size_x       = req_reg.rect_width;
                result_next.size_y       = req_reg.rect_height;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration, table occupancy and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_cfg_reg      <= affra_pkg::ATLAS_WIDTH_RESET;
            ah_cfg_reg      <= affra_pkg::ATLAS_HEIGHT_RESET;
            layers_cfg_reg  <= affra_pkg::ATLAS_LAYERS_RESET;
            entry_valid_reg <= '0;
            layer_reg       <= '0;
            scan_i_reg      <= '0;
            scan_j_reg      <= '0;
            found_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    affra_pkg::CFG_ATLAS_WIDTH:  aw_cfg_reg     <= cfg_data;
                    affra_pkg::CFG_ATLAS_HEIGHT: ah_cfg_reg     <= cfg_data;
                    affra_pkg::CFG_ATLAS_LAYERS: layers_cfg_reg <= cfg_data[affra_pkg::LCNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit)
            begin
                entry_valid_reg[free_idx] <= 1'b1;
            end
            if (cmd.release_slot)
            begin
                entry_valid_reg[req_reg.slot] <= 1'b0;
            end
            if (cmd.layer_clear)
            begin
                layer_reg <= '0;
            end
            else if (cmd.layer_inc)
            begin
                layer_reg <= layer_reg + affra_pkg::LCNT_W'(1);
            end
            if (cmd.scan_init)
            begin
                scan_i_reg <= '0;
                scan_j_reg <= '0;
                found_reg  <= 1'b0;
            end
            else if (cmd.cand_check)
            begin
                if (fits && better)
                begin
                    found_reg <= 1'b1;
                end
                if (next_j_ok)
                begin
                    scan_j_reg <= next_j;
                end
                else
                begin
                    scan_i_reg <= next_i;
                    scan_j_reg <= '0;
                end
            end
        end
    end

    // Payload: request, table contents, candidate and best origin, response.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg <= request;
            w1_reg  <= {1'b0, request.rect_width} + affra_pkg::EXT_W'(1);
            h1_reg  <= {1'b0, request.rect_height} + affra_pkg::EXT_W'(1);
        end
        if (cmd.cand_load)
        begin
            cand_x_reg  <= load_x;
            cand_xe_reg <= load_xe;
            cand_y_reg  <= load_y;
            cand_ye_reg <= load_ye;
        end
        if (cmd.cand_check && fits && better)
        begin
            best_x_reg <= cand_x_reg[affra_pkg::COORD_W-1:0];
            best_y_reg <= cand_y_reg[affra_pkg::COORD_W-1:0];
        end
        if (cmd.commit)
        begin
            entry_x_reg[free_idx]     <= best_x_reg;
            entry_y_reg[free_idx]     <= best_y_reg;
            entry_layer_reg[free_idx] <= layer_reg[affra_pkg::LAYER_W-1:0];
            entry_w_reg[free_idx]     <= req_reg.rect_width;
            entry_h_reg[free_idx]     <= req_reg.rect_height;
            entry_far_x_reg[free_idx] <= commit_far_x;
            entry_far_y_reg[free_idx] <= commit_far_y;
        end
        if (cmd.resp_load)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        st.action     = req_reg.action;
        st.fmt_ok     = (req_reg.channel_count == affra_pkg::REQUIRED_CHANNELS);
        st.table_full = table_full;
        st.slot_hit   = entry_valid_reg[req_reg.slot];
        st.no_layers  = (nl == '0);
        st.layer_last = ((layer_reg + affra_pkg::LCNT_W'(1)) >= nl);
        st.scan_last  = !next_i_ok && !next_j_ok;
        st.found      = found_reg;
    end

    assign result = result_reg;

    a_commit_has_place: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!table_full && found_reg))
        else $error("commit without a free slot or a found origin");

    a_release_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.release_slot |-> entry_valid_reg[req_reg.slot])
        else $error("release of an empty slot");

    a_scan_on_candidates: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cand_load |-> (cmask[scan_i_reg] && cmask[scan_j_reg]))
        else $error("candidate index points at an absent edge");

endmodule

// ----- design/affra_ctrl.sv -----
// Controller of the atlas allocator: sequences decode, the layer and candidate
// scan, table updates and the response strobe. Commands affra_dp.
// Depends on affra_pkg.
module affra_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  affra_pkg::dp_status_t st,
    output affra_pkg::ctrl_cmd_t  cmd,
    output logic                  busy,
    output logic                  done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD,
        S_CHECK,
        S_LAYER_END
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.action)
                    affra_pkg::ACT_ALLOC:
                    begin
                        if (!st.fmt_ok || st.table_full || st.no_layers)
                        begin
                            cmd.resp_load   = 1'b1;
                            cmd.resp_kind   = affra_pkg::RESP_STATUS;
                            cmd.resp_status = !st.fmt_ok     ? affra_pkg::ST_BAD_FORMAT :
                                              st.table_full  ? affra_pkg::ST_TABLE_FULL :
                                                               affra_pkg::ST_NO_SPACE;
                            done_next       = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.layer_clear = 1'b1;
                            cmd.scan_init   = 1'b1;
                            state_next      = S_LOAD;
                        end
                    end
                    affra_pkg::ACT_LOOKUP:
                    begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_kind   = st.slot_hit ? affra_pkg::RESP_LOOKUP
                                                      : affra_pkg::RESP_ECHO;
                        cmd.resp_status = st.slot_hit ? affra_pkg::ST_OK
                                                      : affra_pkg::ST_EMPTY_SLOT;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    affra_pkg::ACT_RELEASE:
                    begin
                        cmd.release_slot = st.slot_hit;
                        cmd.resp_load    = 1'b1;
                        cmd.resp_kind    = affra_pkg::RESP_ECHO;
                        cmd.resp_status  = st.slot_hit ? affra_pkg::ST_OK
                                                       : affra_pkg::ST_EMPTY_SLOT;
                        done_next        = 1'b1;
                        state_next       = S_IDLE;
                    end
                    default:
                    begin
                        cmd.resp_load   = 1'b1;
                        cmd.resp_kind   = affra_pkg::RESP_STATUS;
                        cmd.resp_status = affra_pkg::ST_BAD_FORMAT;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                endcase
            end
            S_LOAD:
            begin
                cmd.cand_load = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.cand_check = 1'b1;
                state_next     = st.scan_last ? S_LAYER_END : S_LOAD;
            end
            S_LAYER_END:
            begin
                if (st.found)
                begin
                    cmd.commit      = 1'b1;
                    cmd.resp_load   = 1'b1;
                    cmd.resp_kind   = affra_pkg::RESP_ALLOC;
                    cmd.resp_status = affra_pkg::ST_OK;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (st.layer_last)
                begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_kind   = affra_pkg::RESP_STATUS;
                    cmd.resp_status = affra_pkg::ST_NO_SPACE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.layer_inc = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

endmodule

// ----- design/atlas_first_fit_rect_allocator_top.sv -----
// Top level of the layered atlas first-fit rectangle allocator.
// Instantiates affra_ctrl and affra_dp; depends on affra_pkg.
//
// Usage: an item on request is taken at a rising edge where start is high and
// busy is low. Its one result appears on result, marked by done, which is high
// for exactly one cycle; the receiver cannot stall, so it must take the result then. A new
// item may be started in the same cycle that done is high.
// Lookup, release, unused actions and failed allocate checks are answered in the
// decode state. An allocate that searches tries the layers in order; on each
// layer it visits every pair of candidate row and column edges (zero and just
// past the far edge of each stored rectangle on that layer), loading each pair
// and then checking it against the whole table. One item is in flight at a time.
// Configuration (atlas width, height, layer count) is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce; writes take effect at once.
// Reset clears the table, restores the configuration defaults and leaves the
// block idle with no pending result.
module atlas_first_fit_rect_allocator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  affra_pkg::request_t               request,
    output logic                              busy,
    output logic                              done,
    output affra_pkg::result_t                result,
    input  logic                              cfg_we,
    input  logic [affra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [affra_pkg::CFG_DATA_W-1:0]  cfg_data
);

    affra_pkg::ctrl_cmd_t  cmd;
    affra_pkg::dp_status_t st;

    affra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    affra_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd),
        .st        (st),
        .result    (result)
    );

endmodule

// ----- bench/atlas_alloc_checker.sv -----
// Checker for the layered atlas rectangle allocator: tracks configuration writes,
// predicts the result of every accepted item and compares it with the block.
// Depends on affra_pkg.
module atlas_alloc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  affra_pkg::request_t               request,
    input  logic                              done,
    input  affra_pkg::result_t                result,
    input  logic                              cfg_we,
    input  logic [affra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [affra_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                failures,
    output int                                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import affra_pkg::*;

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [LCNT_W-1:0]  layers_reg;

    logic               slot_used   [NUM_SLOTS];
    logic [COORD_W-1:0] slot_x      [NUM_SLOTS];
    logic [COORD_W-1:0] slot_y      [NUM_SLOTS];
    logic [LAYER_W-1:0] slot_layer  [NUM_SLOTS];
    logic [SIZE_W-1:0]  slot_w      [NUM_SLOTS];
    logic [SIZE_W-1:0]  slot_h      [NUM_SLOTS];

    int unsigned fit_x;
    int unsigned fit_y;
    result_t     placements_due [$];
    result_t     want;
    int          errors_seen = 0;
    int          s;

    assign failures = errors_seen;

    // Touching edges count as overlap, so the compares are inclusive.
    function automatic bit rect_fits(input int unsigned x, input int unsigned y,
                                     input int unsigned layer, input int unsigned w,
                                     input int unsigned h, input int unsigned aw,
                                     input int unsigned ah);
        int unsigned ex, ey, ew, eh;
        int i;
        if (x >= aw || y >= ah || x + w > aw || y + h > ah)
            return 1'b0;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_used[i] && slot_layer[i] == layer)
            begin
                ex = slot_x[i];
                ey = slot_y[i];
                ew = slot_w[i];
                eh = slot_h[i];
                if (ex <= x + w && ex + ew >= x && ey <= y + h && ey + eh >= y)
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // The first origin in row-major order always sits at zero or just past the far
    // edge of some stored rectangle, so only those rows and columns are tried.
    function automatic bit search_layer(input int unsigned layer, input int unsigned w,
                                        input int unsigned h, input int unsigned aw,
                                        input int unsigned ah);
        int unsigned col [NUM_SLOTS+1];
        int unsigned row [NUM_SLOTS+1];
        int n, i, j;
        bit found;
        n = 1;
        found = 1'b0;
        col[0] = 0;
        row[0] = 0;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_used[i] && slot_layer[i] == layer)
            begin
                col[n] = slot_x[i] + slot_w[i] + 1;
                row[n] = slot_y[i] + slot_h[i] + 1;
                n++;
            end
        end
        for (i = 0; i < n; i++)
        begin
            for (j = 0; j < n; j++)
            begin
                if (!(found && (row[i] > fit_y || (row[i] == fit_y && col[j] >= fit_x))))
                begin
                    if (rect_fits(col[j], row[i], layer, w, h, aw, ah))
                    begin
                        found = 1'b1;
                        fit_x = col[j];
                        fit_y = row[i];
                    end
                end
            end
        end
        return found;
    endfunction

    function automatic result_t serve_request(input request_t rq);
        result_t r;
        int unsigned aw, ah, nl, lyr;
        int free_slot, k;
        r = '0;
        case (rq.action)
            ACT_ALLOC:
            begin
                aw = (width_reg > MAX_DIM) ? MAX_DIM : width_reg;
                ah = (height_reg > MAX_DIM) ? MAX_DIM : height_reg;
                nl = (layers_reg > MAX_LAYERS) ? MAX_LAYERS : layers_reg;
                if (rq.channel_count != REQUIRED_CHANNELS)
                begin
                    r.status = ST_BAD_FORMAT;
                    return r;
                end
                free_slot = -1;
                for (k = NUM_SLOTS - 1; k >= 0; k--)
                begin
                    if (!slot_used[k])
                        free_slot = k;
                end
                if (free_slot < 0)
                begin
                    r.status = ST_TABLE_FULL;
                    return r;
                end
                for (lyr = 0; lyr < nl; lyr++)
                begin
                    if (search_layer(lyr, rq.rect_width, rq.rect_height, aw, ah))
                    begin
                        slot_used[free_slot]  = 1'b1;
                        slot_x[free_slot]     = fit_x[COORD_W-1:0];
                        slot_y[free_slot]     = fit_y[COORD_W-1:0];
                        slot_layer[free_slot] = lyr[LAYER_W-1:0];
                        slot_w[free_slot]     = rq.rect_width;
                        slot_h[free_slot]     = rq.rect_height;
                        r.status       = ST_OK;
                        r.slot_out     = free_slot[SLOT_W-1:0];
                        r.origin_x     = fit_x[COORD_W-1:0];
                        r.origin_y     = fit_y[COORD_W-1:0];
                        r.origin_layer = lyr[LAYER_W-1:0];
                        r.size_x       = rq.rect_width;
                        r.size_y       = rq.rect_height;
                        return r;
                    end
                end
                r.status = ST_NO_SPACE;
            end
            ACT_LOOKUP, ACT_RELEASE:
            begin
                r.slot_out = rq.slot;
                if (!slot_used[rq.slot])
                    r.status = ST_EMPTY_SLOT;
                else if (rq.action == ACT_LOOKUP)
                begin
                    r.origin_x     = slot_x[rq.slot];
                    r.origin_y     = slot_y[rq.slot];
                    r.origin_layer = slot_layer[rq.slot];
                    r.size_x       = slot_w[rq.slot];
                    r.size_y       = slot_h[rq.slot];
                end
                else
                    slot_used[rq.slot] = 1'b0;
            end
            default:
                r.status = ST_BAD_FORMAT;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = ATLAS_WIDTH_RESET;
            height_reg = ATLAS_HEIGHT_RESET;
            layers_reg = ATLAS_LAYERS_RESET;
            for (s = 0; s < NUM_SLOTS; s++)
                slot_used[s] = 1'b0;
            placements_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (placements_due.size() == 0)
                begin
                    $error("result arrived with no item waiting for one");
                    errors_seen++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    check_field("status", want.status, result.status);
                    check_field("slot_out", want.slot_out, result.slot_out);
                    check_field("origin_x", want.origin_x, result.origin_x);
                    check_field("origin_y", want.origin_y, result.origin_y);
                    check_field("origin_layer", want.origin_layer, result.origin_layer);
                    check_field("size_x", want.size_x, result.size_x);
                    check_field("size_y", want.size_y, result.size_y);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ATLAS_WIDTH:  width_reg  = cfg_data;
                    CFG_ATLAS_HEIGHT: height_reg = cfg_data;
                    CFG_ATLAS_LAYERS: layers_reg = cfg_data[LCNT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                placements_due.push_back(serve_request(request));
            outstanding <= placements_due.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for atlas_first_fit_rect_allocator_top: drives directed and random
// allocate, lookup and release items over several atlas settings and gives the verdict.
// Depends on affra_pkg, the block and atlas_alloc_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int SETTLE_CYCLES = 1400;

    localparam logic [1:0]                      ACT_UNUSED = 2'd3;
    localparam logic [affra_pkg::CFG_IDX_W-1:0] CFG_NONE   = 2'd3;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               start     = 1'b0;
    affra_pkg::request_t                request   = '0;
    logic                               busy;
    logic                               done;
    affra_pkg::result_t                 result;
    logic                               cfg_we    = 1'b0;
    logic [affra_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [affra_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

    int failures;
    int outstanding;
    int cycle_count = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b0;

    logic [affra_pkg::CFG_DATA_W-1:0] rand_w;
    logic [affra_pkg::CFG_DATA_W-1:0] rand_h;

    atlas_first_fit_rect_allocator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    atlas_alloc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("atlas_first_fit_rect_allocator_top test failed");
            $finish;
        end
    end

    // The sender works in bursts; between bursts start drops for a random gap.
    task automatic pace();
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                burst_left = $urandom_range(0, 10);
            end
        end
    endtask

    task automatic issue(input affra_pkg::action_t act,
                         input logic [affra_pkg::SLOT_W-1:0] slot,
                         input logic [affra_pkg::SIZE_W-1:0] w,
                         input logic [affra_pkg::SIZE_W-1:0] h,
                         input logic [affra_pkg::CHAN_W-1:0] ch);
        affra_pkg::request_t rq;
        rq.action        = act;
        rq.slot          = slot;
        rq.rect_width    = w;
        rq.rect_height   = h;
        rq.channel_count = ch;
        request <= rq;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pace();
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [affra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [affra_pkg::CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly sizes that fit the current atlas, now and then any 13-bit value.
    function automatic logic [affra_pkg::SIZE_W-1:0] pick_size(input int max_side);
        if ($urandom_range(0, 19) == 0)
            return affra_pkg::SIZE_W'($urandom_range(0, 8191));
        return affra_pkg::SIZE_W'($urandom_range(0, max_side));
    endfunction

    function automatic logic [affra_pkg::SLOT_W-1:0] any_slot();
        return affra_pkg::SLOT_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [affra_pkg::SIZE_W-1:0] any_size();
        return affra_pkg::SIZE_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [affra_pkg::CHAN_W-1:0] any_chan();
        return affra_pkg::CHAN_W'($urandom_range(0, 15));
    endfunction

    task automatic random_item(input int max_side);
        int pick;
        logic [affra_pkg::CHAN_W-1:0] ch;
        pick = $urandom_range(0, 99);
        ch = ($urandom_range(0, 15) == 0) ? any_chan() : affra_pkg::REQUIRED_CHANNELS;
        if (pick < 50)
            issue(affra_pkg::ACT_ALLOC, any_slot(), pick_size(max_side),
                  pick_size(max_side), ch);
        else if (pick < 72)
            issue(affra_pkg::ACT_LOOKUP, any_slot(), any_size(), any_size(), any_chan());
        else if (pick < 94)
            issue(affra_pkg::ACT_RELEASE, any_slot(), any_size(), any_size(), any_chan());
        else
            issue(affra_pkg::action_t'(ACT_UNUSED), any_slot(), any_size(), any_size(),
                  any_chan());
    endtask

    // Each setting is written only once the block has delivered every result.
    task automatic run_phase(input logic [affra_pkg::CFG_DATA_W-1:0] aw,
                             input logic [affra_pkg::CFG_DATA_W-1:0] ah,
                             input logic [affra_pkg::CFG_DATA_W-1:0] layers,
                             input int max_side, input int count, input bit gaps);
        drain();
        write_reg(affra_pkg::CFG_ATLAS_WIDTH, aw);
        write_reg(affra_pkg::CFG_ATLAS_HEIGHT, ah);
        write_reg(affra_pkg::CFG_ATLAS_LAYERS, layers);
        gaps_on    = gaps;
        burst_left = 0;
        repeat (count) random_item(max_side);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items on the reset setting of 2048 x 2048 with four layers.
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd0, 13'd0, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_ALLOC, 4'd9, 13'd100, 13'd50, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd2048, 13'd2048, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd2048, 13'd2047, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd4096, 13'd4096, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd8191, 13'd8191, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_ALLOC, 4'd15, 13'd8191, 13'd8191, 4'd0);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd1, 13'd1, 4'd15);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd1, 13'd1, 4'd3);
        issue(affra_pkg::action_t'(ACT_UNUSED), 4'd15, 13'd8191, 13'd8191, 4'd15);
        issue(affra_pkg::action_t'(ACT_UNUSED), 4'd0, 13'd0, 13'd0,
              affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_LOOKUP, 4'd0, 13'd0, 13'd0, 4'd0);
        issue(affra_pkg::ACT_LOOKUP, 4'd1, 13'd8191, 13'd8191, 4'd15);
        issue(affra_pkg::ACT_LOOKUP, 4'd15, 13'd0, 13'd0, 4'd0);
        issue(affra_pkg::ACT_RELEASE, 4'd1, 13'd0, 13'd0, 4'd0);
        issue(affra_pkg::ACT_RELEASE, 4'd1, 13'd0, 13'd0, 4'd0);
        issue(affra_pkg::ACT_LOOKUP, 4'd1, 13'd0, 13'd0, 4'd0);
        issue(affra_pkg::ACT_RELEASE, 4'd15, 13'd8191, 13'd8191, 4'd15);
        issue(affra_pkg::ACT_ALLOC, 4'd0, 13'd30, 13'd30, affra_pkg::REQUIRED_CHANNELS);
        issue(affra_pkg::ACT_LOOKUP, 4'd1, 13'd8191, 13'd8191, 4'd15);
        issue(affra_pkg::ACT_RELEASE, 4'd0, 13'd0, 13'd0, 4'd0);

        drain();
        write_reg(CFG_NONE, affra_pkg::CFG_DATA_W'($urandom_range(0, 8191)));

        run_phase(13'd2048, 13'd2048, 13'd4, 700, 25, 1'b1);
        run_phase(13'd64, 13'd48, 13'd2, 40, 20, 1'b1);
        // Oversized setting: clamped to the largest atlas; no idling here.
        run_phase(13'h1fff, 13'd4096, 13'h1fff, 300, 20, 1'b0);
        run_phase(13'd1, 13'd1, 13'd1, 1, 12, 1'b1);
        run_phase(13'd0, 13'd4096, 13'd0, 16, 8, 1'b1);
        rand_w = affra_pkg::CFG_DATA_W'($urandom_range(16, 4096));
        rand_h = affra_pkg::CFG_DATA_W'($urandom_range(16, 4096));
        run_phase(rand_w, rand_h, affra_pkg::CFG_DATA_W'($urandom_range(1, 16)),
                  int'(rand_w) / 3, 34, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("atlas_first_fit_rect_allocator_top test passed");
        else
            $display("atlas_first_fit_rect_allocator_top test failed");
        $finish;
    end

endmodule
